// ===== src/assert_macros.svh =====
// Assertion macros shared by the cursor sequence store RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, switched off while reset is asserted.
`define CSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/css_pkg.sv =====
// Package for the cursor sequence store: command and result types, codes and defaults.
// No dependencies.
`default_nettype none

package css_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    // Position width that covers every supported depth, including the one-past-end value.
    localparam int POS_W          = 11;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_INSERT  = 3'd2,
        OP_ATTACH  = 3'd3,
        OP_REMOVE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ITEM = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_UP   = 2'd1,
        SH_DOWN = 2'd2
    } t_shift;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] entry_value;
    } t_cmd;

    typedef struct packed {
        logic        has_item;
        logic [31:0] current_value;
        logic [5:0]  item_count;
        t_status     status;
    } t_result;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        t_shift           shift;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rd_idx;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/css_cell.sv =====
// One storage cell of the sequence row: holds one entry and shifts to or from its neighbours.
// Depends on css_pkg.
`default_nettype none

module css_cell #(
    parameter int DATA_WIDTH = css_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire css_pkg::t_cell_ctl    i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_new,
    input  wire logic [DATA_WIDTH-1:0] i_left,
    input  wire logic [DATA_WIDTH-1:0] i_right,
    output logic      [DATA_WIDTH-1:0] o_q,
    output logic      [DATA_WIDTH-1:0] o_rd
);
    import css_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;

    always_comb begin
        n_q = r_q;
        case (i_ctl.shift)
            SH_UP: begin
                if (IDX == i_ctl.pos) begin
                    n_q = i_new;
                end else if (IDX > i_ctl.pos) begin
                    n_q = i_left;
                end
            end
            SH_DOWN: begin
                if (IDX >= i_ctl.pos) begin
                    n_q = i_right;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q  = r_q;
    // Only the addressed cell drives its value; the controller ORs all cells together.
    assign o_rd = (i_ctl.rd_idx == IDX) ? r_q : '0;

endmodule

`default_nettype wire

// ===== src/cursor_sequence_store.sv =====
// Top level of the cursor sequence store: controller, cursor and count, and the row of cells.
// Depends on css_pkg, css_cell and assert_macros.svh.
`default_nettype none

// An ordered sequence of up to DEPTH values with a cursor. Each command (start, advance,
// insert, attach, remove) is taken when start is high and busy is low; busy never rises,
// so a command may be issued in every cycle. Its result appears in the next cycle for exactly
// one cycle with o_strobe high and must be captured then: it cannot be held off. The
// throughput is one command per cycle, set by the row of cells, which all shift in parallel
// in the same cycle, and by the one-of-DEPTH read of the current entry.
// Insert or attach on a full store and advance or remove without a current entry report an
// error status and leave the contents unchanged. Entries need no clearing after reset.
module cursor_sequence_store #(
    parameter int DEPTH      = css_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = css_pkg::DATA_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire css_pkg::t_cmd    i_cmd,
    output logic                  o_strobe,
    output css_pkg::t_result      o_result
);
    import css_pkg::*;

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [CNT_W-1:0]      r_cur;
    logic [CNT_W-1:0]      n_cur;
    logic                  r_strobe;
    t_result               r_result;
    t_result               n_result;

    logic                  accept;
    logic                  cur_valid;
    logic                  full;
    logic                  use_new;
    logic                  has_item;
    t_shift                shift;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      rd_idx;
    t_status               status;
    t_cell_ctl             ctl;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd [DEPTH];

    // Every command completes in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign din    = DATA_WIDTH'(i_cmd.entry_value);

    assign cur_valid = r_cur < r_cnt;
    assign full      = r_cnt == CNT_W'(DEPTH);

    always_comb begin
        n_cnt   = r_cnt;
        n_cur   = r_cur;
        shift   = SH_HOLD;
        pos     = r_cur;
        rd_idx  = r_cur;
        status  = ST_OK;
        use_new = 1'b0;
        case (i_cmd.operation)
            OP_START: begin
                if (r_cnt != '0) begin
                    n_cur  = '0;
                    rd_idx = '0;
                end
            end
            OP_ADVANCE: begin
                if (cur_valid) begin
                    n_cur  = r_cur + CNT_W'(1);
                    rd_idx = r_cur + CNT_W'(1);
                end else begin
                    status = ST_NO_ITEM;
                end
            end
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    pos     = cur_valid ? r_cur : '0;
                    n_cur   = pos;
                    shift   = SH_UP;
                    n_cnt   = r_cnt + CNT_W'(1);
                    use_new = 1'b1;
                end
            end
            OP_ATTACH: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    pos     = cur_valid ? r_cur + CNT_W'(1) : r_cnt;
                    n_cur   = pos;
                    shift   = SH_UP;
                    n_cnt   = r_cnt + CNT_W'(1);
                    use_new = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!cur_valid) begin
                    status = ST_NO_ITEM;
                end else begin
                    // The entry that follows slides onto the cursor position.
                    shift  = SH_DOWN;
                    n_cnt  = r_cnt - CNT_W'(1);
                    rd_idx = r_cur + CNT_W'(1);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign ctl.shift  = accept ? shift : SH_HOLD;
    assign ctl.pos    = POS_W'(pos);
    assign ctl.rd_idx = POS_W'(rd_idx);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_q;
        logic [DATA_WIDTH-1:0] right_q;

        if (g == 0) begin : g_first
            assign left_q = '0;
        end else begin : g_mid_l
            assign left_q = cell_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_q = '0;
        end else begin : g_mid_r
            assign right_q = cell_q[g+1];
        end

        css_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_new   (din),
            .i_left  (left_q),
            .i_right (right_q),
            .o_q     (cell_q[g]),
            .o_rd    (cell_rd[g])
        );
    end

    always_comb begin
        rd_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_val = rd_val | cell_rd[i];
        end
    end

    assign has_item = n_cur < n_cnt;

    always_comb begin
        n_result.has_item      = has_item;
        n_result.item_count    = 6'(n_cnt);
        n_result.status        = status;
        if (!has_item) begin
            n_result.current_value = '0;
        end else if (use_new) begin
            n_result.current_value = 32'(din);
        end else begin
            n_result.current_value = 32'(rd_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_cur    <= CNT_W'(DEPTH);
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (accept) begin
                r_cnt <= n_cnt;
                r_cur <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `CSS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "count exceeds depth")
    `CSS_ASSERT_ALWAYS(a_strobe_follows, i_clk, (i_rst_n && accept) |=> o_strobe, "transfer lost")
    `CSS_ASSERT(a_full_status, i_clk, i_rst_n, (o_strobe && o_result.status == ST_FULL) |-> (r_cnt == CNT_W'(DEPTH)), "full status on a store that is not full")
    `CSS_ASSERT(a_no_item_zero, i_clk, i_rst_n, (o_strobe && !o_result.has_item) |-> (o_result.current_value == '0), "value reported without a current entry")
    `CSS_ASSERT(a_has_item_cursor, i_clk, i_rst_n, (o_strobe && o_result.has_item) |-> (r_cur < r_cnt), "current entry reported beyond the count")

endmodule

`default_nettype wire
